FILE: rtl/lkvc_pkg.sv
// lkvc_pkg: sizes, types and the command struct shared by the lru key-value cache
// depends on nothing; used by lkvc_ctrl, lkvc_dp, lru_key_value_cache and lkvc_checker
package lkvc_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 16;
   localparam int KEY_W      = 16;   // width of the key and evicted key ports
   localparam int VALUE_W    = 32;
   localparam int CAP_BITS   = 5;
   localparam int CAP_RESET  = 16;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_BITS  = IDX_BITS;
   localparam int OCC_BITS   = $clog2(ENTRIES + 1);
   localparam int CMP_BITS   = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef logic [KEY_BITS-1:0]  key_type;
   typedef logic [RANK_BITS-1:0] rank_type;
   typedef logic [IDX_BITS-1:0]  idx_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request item
      logic execute;   // look up, update the store and register the result
   } cmd_type;

endpackage

FILE: rtl/lkvc_ctrl.sv
// lkvc_ctrl: controller state machine of the lru key-value cache
// depends on lkvc_pkg; drives the command struct of lkvc_dp
module lkvc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output lkvc_pkg::cmd_type cmd
);

   lkvc_pkg::state_type state_ff, state_in;
   logic                accept;

   assign accept = start && !busy;
   assign busy   = reset || (state_ff == lkvc_pkg::ST_EXEC);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (accept) state_in = lkvc_pkg::ST_EXEC;
         end
         lkvc_pkg::ST_EXEC: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkvc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.capture = accept;
   assign cmd.execute = (state_ff == lkvc_pkg::ST_EXEC);

endmodule

FILE: rtl/lkvc_dp.sv
// lkvc_dp: datapath of the lru key-value cache: tag store, values, recency ranks,
// occupancy, capacity register and result register; depends on lkvc_pkg
module lkvc_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lkvc_pkg::cmd_type                    cmd,
   input  logic                                 req_func,
   input  logic [lkvc_pkg::KEY_W-1:0]           req_key,
   input  logic signed [lkvc_pkg::VALUE_W-1:0]  req_value,
   input  logic                                 csr_valid,
   input  logic [lkvc_pkg::CAP_BITS-1:0]        csr_capacity_in_use,
   output logic                                 rsp_strobe,
   output logic                                 rsp_hit,
   output logic signed [lkvc_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic                                 rsp_evicted,
   output logic [lkvc_pkg::KEY_W-1:0]           rsp_evicted_key
);

   // request item
   logic                                func_ff;
   lkvc_pkg::key_type                   key_ff;
   logic signed [lkvc_pkg::VALUE_W-1:0] value_ff;

   // store
   lkvc_pkg::key_type                   ekey_ff   [lkvc_pkg::ENTRIES];
   lkvc_pkg::key_type                   ekey_in   [lkvc_pkg::ENTRIES];
   logic signed [lkvc_pkg::VALUE_W-1:0] evalue_ff [lkvc_pkg::ENTRIES];
   logic signed [lkvc_pkg::VALUE_W-1:0] evalue_in [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::ENTRIES-1:0]        valid_ff, valid_in;
   lkvc_pkg::rank_type                  rank_ff   [lkvc_pkg::ENTRIES];
   lkvc_pkg::rank_type                  rank_in   [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::OCC_BITS-1:0]       occ_ff, occ_in;
   logic [lkvc_pkg::CAP_BITS-1:0]       cap_ff;

   // result register
   logic                                strobe_ff;
   logic                                hit_ff, hit_in;
   logic signed [lkvc_pkg::VALUE_W-1:0] rd_ff, rd_in;
   logic                                ev_ff, ev_in;
   logic [lkvc_pkg::KEY_W-1:0]          evkey_ff, evkey_in;

   // lookup
   logic [lkvc_pkg::ENTRIES-1:0]        hit_vec, victim_vec;
   logic                                found_any, free_any, victim_any;
   lkvc_pkg::idx_type                   found_idx, free_idx, victim_idx, target_idx;
   lkvc_pkg::rank_type                  oldest_rank, touch_ref;
   logic [lkvc_pkg::CMP_BITS-1:0]       eff_cap, occ_ext;
   logic                                is_put, full, do_hit, do_evict, do_fill, do_write;

   assign is_put      = (func_ff == lkvc_pkg::FUNC_PUT);
   assign oldest_rank = lkvc_pkg::RANK_BITS'(occ_ff - 1'b1);

   always_comb begin
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         hit_vec[i]    = valid_ff[i] && (ekey_ff[i] == key_ff);
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == oldest_rank);
      end
   end

   // lowest-numbered match, free slot and victim
   always_comb begin
      found_any  = 1'b0;
      free_any   = 1'b0;
      victim_any = 1'b0;
      found_idx  = '0;
      free_idx   = '0;
      victim_idx = '0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         if (hit_vec[i] && !found_any) begin
            found_any = 1'b1;
            found_idx = lkvc_pkg::IDX_BITS'(i);
         end
         if (!valid_ff[i] && !free_any) begin
            free_any = 1'b1;
            free_idx = lkvc_pkg::IDX_BITS'(i);
         end
         if (victim_vec[i] && !victim_any) begin
            victim_any = 1'b1;
            victim_idx = lkvc_pkg::IDX_BITS'(i);
         end
      end
   end

   // zero capacity counts as one, anything above the store size saturates
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = lkvc_pkg::CMP_BITS'(1);
      end else if (lkvc_pkg::CMP_BITS'(cap_ff) > lkvc_pkg::CMP_BITS'(lkvc_pkg::ENTRIES)) begin
         eff_cap = lkvc_pkg::CMP_BITS'(lkvc_pkg::ENTRIES);
      end else begin
         eff_cap = lkvc_pkg::CMP_BITS'(cap_ff);
      end
   end

   assign occ_ext  = lkvc_pkg::CMP_BITS'(occ_ff);
   assign full     = (occ_ext >= eff_cap) || !free_any;
   assign do_hit   = found_any;
   assign do_evict = is_put && !found_any && full && victim_any;
   assign do_fill  = is_put && !found_any && !do_evict && free_any;
   assign do_write = (do_hit && is_put) || do_evict || do_fill;

   always_comb begin
      if (do_hit) begin
         target_idx = found_idx;
         touch_ref  = rank_ff[found_idx];
      end else if (do_evict) begin
         target_idx = victim_idx;
         touch_ref  = oldest_rank;
      end else begin
         target_idx = free_idx;
         touch_ref  = oldest_rank;
      end
   end

   // next state of the store
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         ekey_in[i]   = ekey_ff[i];
         evalue_in[i] = evalue_ff[i];
         rank_in[i]   = rank_ff[i];
      end
      if (cmd.execute && (do_hit || do_evict || do_fill)) begin
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            if (lkvc_pkg::IDX_BITS'(i) == target_idx) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (do_fill || (rank_ff[i] < touch_ref))) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         if (do_write) begin
            ekey_in[target_idx]   = key_ff;
            evalue_in[target_idx] = value_ff;
         end
         if (do_fill) begin
            valid_in[target_idx] = 1'b1;
            occ_in               = occ_ff + 1'b1;
         end
      end
   end

   // result
   always_comb begin
      hit_in   = found_any;
      ev_in    = do_evict;
      evkey_in = '0;
      if (do_evict) evkey_in = lkvc_pkg::KEY_W'(ekey_ff[victim_idx]);
      if (is_put) begin
         rd_in = '0;
      end else if (found_any) begin
         rd_in = evalue_ff[found_idx];
      end else begin
         rd_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         key_ff   <= req_key[lkvc_pkg::KEY_BITS-1:0];
         value_ff <= req_value;
      end
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         ekey_ff[i]   <= ekey_in[i];
         evalue_ff[i] <= evalue_in[i];
      end
      if (cmd.execute) begin
         hit_ff   <= hit_in;
         rd_ff    <= rd_in;
         ev_ff    <= ev_in;
         evkey_ff <= evkey_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         occ_ff    <= '0;
         cap_ff    <= lkvc_pkg::CAP_BITS'(lkvc_pkg::CAP_RESET);
         strobe_ff <= 1'b0;
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff  <= valid_in;
         occ_ff    <= occ_in;
         strobe_ff <= cmd.execute;
         if (csr_valid) cap_ff <= csr_capacity_in_use;
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_read_value  = rd_ff;
   assign rsp_evicted     = ev_ff;
   assign rsp_evicted_key = evkey_ff;

endmodule

FILE: rtl/lru_key_value_cache.sv
// lru_key_value_cache: 16-entry fully associative key-value store, lru replacement
// capture latches the item; the execute state registers the result and its strobe
// busy refuses new items; it is high in reset and for the one cycle in which
// the parallel tag compare and the rank update of all entries run
// reset clears valid bits, ranks and occupancy and sets the capacity to 16
// results cannot be held off; depends on lkvc_pkg, lkvc_ctrl and lkvc_dp
module lru_key_value_cache (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_func,
   input  logic [lkvc_pkg::KEY_W-1:0]           req_key,
   input  logic signed [lkvc_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_strobe,
   output logic                                 rsp_hit,
   output logic signed [lkvc_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic                                 rsp_evicted,
   output logic [lkvc_pkg::KEY_W-1:0]           rsp_evicted_key,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lkvc_pkg::CAP_BITS-1:0]        csr_capacity_in_use
);

   lkvc_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   lkvc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   lkvc_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_func            (req_func),
      .req_key             (req_key),
      .req_value           (req_value),
      .csr_valid           (csr_valid),
      .csr_capacity_in_use (csr_capacity_in_use),
      .rsp_strobe          (rsp_strobe),
      .rsp_hit             (rsp_hit),
      .rsp_read_value      (rsp_read_value),
      .rsp_evicted         (rsp_evicted),
      .rsp_evicted_key     (rsp_evicted_key)
   );

endmodule

FILE: rtl/lkvc_checker.sv
// lkvc_checker: port-level assertions for lru_key_value_cache, bound to the top level
// depends on lkvc_pkg and lru_key_value_cache
module lkvc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_strobe,
   input logic                                 rsp_hit,
   input logic signed [lkvc_pkg::VALUE_W-1:0]  rsp_read_value,
   input logic                                 rsp_evicted,
   input logic [lkvc_pkg::KEY_W-1:0]           rsp_evicted_key
);

   // every accepted item is followed by its result strobe
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("no result two cycles after an accepted item");

   // one item in flight: the block is busy right after accepting
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after an accepted item");

   // results are never back to back
   a_no_double_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe in two consecutive cycles");

   // an eviction only comes from a put that missed
   a_evict_is_put_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_evicted) |-> (!rsp_hit && (rsp_read_value == '0)))
      else $error("eviction reported on a hit or a get");

   // no eviction, no evicted key
   a_evkey_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_evicted) |-> (rsp_evicted_key == '0))
      else $error("evicted key without an eviction");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_hit         (rsp_hit),
   .rsp_read_value  (rsp_read_value),
   .rsp_evicted     (rsp_evicted),
   .rsp_evicted_key (rsp_evicted_key)
);
